### hw/rtl/scb_pkg.sv
// Shared types, constants and register map for the scaled glyph blitter.
`timescale 1ns / 1ps
package scb_pkg;

  localparam int GLYPH_SLOTS_DEF = 256;
  localparam int MAX_GLYPH_W_DEF = 16;
  localparam int MAX_GLYPH_H_DEF = 16;
  localparam int MAX_SCALE_DEF   = 4;

  localparam int MAX_ROWS_OUT = 64;
  localparam int MASK_W       = 64;
  localparam int APB_AW       = 5;

  localparam logic [7:0] FALLBACK_CODE = 8'h3F;

  localparam logic [12:0] SCREEN_W_RST   = 13'd1024;
  localparam logic [12:0] SCREEN_H_RST   = 13'd768;
  localparam logic [13:0] LINE_PITCH_RST = 14'd1024;
  localparam logic [4:0]  GLYPH_W_RST    = 5'd8;
  localparam logic [4:0]  GLYPH_H_RST    = 5'd16;
  localparam logic [2:0]  TEXT_SCALE_RST = 3'd1;
  localparam logic [8:0]  GLYPH_CNT_RST  = 9'd256;

  typedef enum logic [2:0] {
    REG_SCREEN_W   = 3'd0,
    REG_SCREEN_H   = 3'd1,
    REG_LINE_PITCH = 3'd2,
    REG_GLYPH_W    = 3'd3,
    REG_GLYPH_H    = 3'd4,
    REG_TEXT_SCALE = 3'd5,
    REG_GLYPH_CNT  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROW_RD,
    ST_EMIT
  } state_t;

  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_DRAW = 1'b1;

endpackage

### hw/rtl/scb_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module scb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hw/rtl/scaled_glyph_blitter_top.sv
// Scaled glyph blitter: top level with register port, glyph search and row emitter.
`timescale 1ns / 1ps
// A load transaction writes one glyph row and its slot code in the cycle it is
// accepted. A draw transaction scans the code memory one slot per cycle (up to
// glyph_count slots, fewer when an exact match turns up early, with registered
// read data), then for each glyph row reads the bitmap memory and emits
// text_scale scaled rows, one result per cycle while the output is taken. Draw
// time is bounded by the sequential code scan and the single port of each
// memory. Results sit in an output register, so a new transaction is accepted
// while the last result still waits. Reads of glyph slots or rows never loaded
// return undefined bits; the memories have no reset.
module scaled_glyph_blitter_top
  import scb_pkg::*;
#(
  parameter int GLYPH_SLOTS = GLYPH_SLOTS_DEF,
  parameter int MAX_GLYPH_W = MAX_GLYPH_W_DEF,
  parameter int MAX_GLYPH_H = MAX_GLYPH_H_DEF,
  parameter int MAX_SCALE   = MAX_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [7:0]         slot,
  input  logic [7:0]         char_code,
  input  logic [3:0]         glyph_row,
  input  logic [15:0]        row_bits,
  input  logic [31:0]        color,
  input  logic signed [14:0] pos_x,
  input  logic signed [14:0] pos_y,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] row_y,
  output logic [24:0]        row_base,
  output logic signed [15:0] start_x,
  output logic [MASK_W-1:0]  fg_mask,
  output logic [MASK_W-1:0]  write_mask,
  output logic [31:0]        fg_color,
  output logic               last_row
);

  localparam int SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int CNT_W  = $clog2(GLYPH_SLOTS + 1);
  localparam int ROW_W  = $clog2(MAX_GLYPH_H);
  localparam int BMP_DEPTH = GLYPH_SLOTS << ROW_W;
  localparam int BMP_AW = SLOT_W + ROW_W;

  // configuration registers
  logic [12:0] screen_width, screen_height;
  logic [13:0] line_pitch;
  logic [4:0]  glyph_width, glyph_height;
  logic [2:0]  text_scale;
  logic [8:0]  glyph_count;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_W_RST;
      screen_height <= SCREEN_H_RST;
      line_pitch    <= LINE_PITCH_RST;
      glyph_width   <= GLYPH_W_RST;
      glyph_height  <= GLYPH_H_RST;
      text_scale    <= TEXT_SCALE_RST;
      glyph_count   <= GLYPH_CNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SCREEN_W:   screen_width  <= pwdata[12:0];
        REG_SCREEN_H:   screen_height <= pwdata[12:0];
        REG_LINE_PITCH: line_pitch    <= pwdata[13:0];
        REG_GLYPH_W:    glyph_width   <= pwdata[4:0];
        REG_GLYPH_H:    glyph_height  <= pwdata[4:0];
        REG_TEXT_SCALE: text_scale    <= pwdata[2:0];
        REG_GLYPH_CNT:  glyph_count   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SCREEN_W:   prdata = {19'd0, screen_width};
      REG_SCREEN_H:   prdata = {19'd0, screen_height};
      REG_LINE_PITCH: prdata = {18'd0, line_pitch};
      REG_GLYPH_W:    prdata = {27'd0, glyph_width};
      REG_GLYPH_H:    prdata = {27'd0, glyph_height};
      REG_TEXT_SCALE: prdata = {29'd0, text_scale};
      REG_GLYPH_CNT:  prdata = {23'd0, glyph_count};
      default:        prdata = '0;
    endcase
  end

  // control
  state_t state, state_next;
  logic   in_fire, is_load, load_ok;
  logic   code_we, code_re, bmp_we, bmp_re, out_load;
  logic   chk_hit, scan_done, row_last, scale_end;

  // draw context
  logic [7:0]        draw_code;
  logic [31:0]       draw_color;
  logic [14:0]       draw_px;
  logic [15:0]       ycur;
  logic [4:0]        w;
  logic [5:0]        h;
  logic [2:0]        scale;
  logic [6:0]        ws;
  logic [6:0]        rows;
  logic [CNT_W-1:0]  search_n;

  // search and row counters
  logic [CNT_W-1:0]  scan_idx;
  logic              chk_valid;
  logic [SLOT_W-1:0] chk_idx;
  logic              q_found;
  logic [SLOT_W-1:0] q_idx;
  logic [SLOT_W-1:0] sel;
  logic [ROW_W-1:0]  gr;
  logic [2:0]        sub;
  logic [6:0]        r;

  // memories
  logic [SLOT_W-1:0] code_addr;
  logic [7:0]        code_rdata;
  logic [BMP_AW-1:0] bmp_addr;
  logic [15:0]       bmp_rdata;

  // clamped settings for a new draw
  logic [4:0] w_clamp;
  logic [5:0] h_clamp;
  logic [2:0] s_clamp;
  logic [8:0] hs;

  assign in_fire = in_valid && in_ready;
  assign is_load = (op == OP_LOAD);
  assign load_ok = (32'(slot) < GLYPH_SLOTS) && (32'(glyph_row) < MAX_GLYPH_H);
  assign code_we = in_fire && is_load && load_ok;
  assign bmp_we  = code_we;

  assign w_clamp = (glyph_width == 5'd0) ? 5'd1 :
                   (32'(glyph_width) > MAX_GLYPH_W) ? 5'(MAX_GLYPH_W) : glyph_width;
  assign h_clamp = (glyph_height == 5'd0) ? 6'd1 :
                   (32'(glyph_height) > MAX_GLYPH_H) ? 6'(MAX_GLYPH_H) : {1'b0, glyph_height};
  assign s_clamp = (text_scale == 3'd0) ? 3'd1 :
                   (32'(text_scale) > MAX_SCALE) ? 3'(MAX_SCALE) : text_scale;
  assign hs      = 9'(h_clamp * s_clamp);

  assign chk_hit   = chk_valid && (code_rdata == draw_code);
  assign scan_done = (scan_idx == search_n) && !chk_valid;
  assign row_last  = (7'(r + 7'd1) == rows);
  assign scale_end = (sub == 3'(scale - 3'd1));

  assign code_addr = code_we ? SLOT_W'(slot) : scan_idx[SLOT_W-1:0];
  assign bmp_addr  = bmp_we ? {SLOT_W'(slot), ROW_W'(glyph_row)} : {sel, gr};

  scb_ram #(
    .WIDTH(8),
    .DEPTH(GLYPH_SLOTS)
  ) u_code_ram (
    .clk  (clk),
    .we   (code_we),
    .re   (code_re),
    .addr (code_addr),
    .wdata(char_code),
    .rdata(code_rdata)
  );

  scb_ram #(
    .WIDTH(16),
    .DEPTH(BMP_DEPTH)
  ) u_bmp_ram (
    .clk  (clk),
    .we   (bmp_we),
    .re   (bmp_re),
    .addr (bmp_addr),
    .wdata(row_bits),
    .rdata(bmp_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire && !is_load) state_next = ST_SCAN;
      ST_SCAN:   if (chk_hit || scan_done) state_next = ST_ROW_RD;
      ST_ROW_RD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          if (row_last) begin
            state_next = ST_IDLE;
          end else if (scale_end) begin
            state_next = ST_ROW_RD;
          end
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    code_re  = 1'b0;
    bmp_re   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   code_re  = (scan_idx != search_n);
      ST_ROW_RD: bmp_re   = 1'b1;
      ST_EMIT:   out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // draw context and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
      q_found   <= 1'b0;
      scan_idx  <= '0;
      r         <= '0;
      gr        <= '0;
      sub       <= '0;
    end else begin
      if (in_fire && !is_load) begin
        scan_idx  <= '0;
        chk_valid <= 1'b0;
        q_found   <= 1'b0;
        r         <= '0;
        gr        <= '0;
        sub       <= '0;
      end else if (state == ST_SCAN) begin
        chk_valid <= code_re;
        if (code_re) begin
          scan_idx <= CNT_W'(scan_idx + 1'b1);
        end
        // remember the first fallback slot in case no exact match follows
        if (chk_valid && !q_found && code_rdata == FALLBACK_CODE) begin
          q_found <= 1'b1;
        end
      end else if (out_load && !row_last) begin
        r <= 7'(r + 7'd1);
        if (scale_end) begin
          sub <= '0;
          gr  <= ROW_W'(gr + 1'b1);
        end else begin
          sub <= 3'(sub + 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !is_load) begin
      draw_code  <= char_code;
      draw_color <= color;
      draw_px    <= pos_x;
      ycur       <= {pos_y[14], pos_y};
      w          <= w_clamp;
      h          <= h_clamp;
      scale      <= s_clamp;
      ws         <= 7'(w_clamp * s_clamp);
      rows       <= (hs > 9'(MAX_ROWS_OUT)) ? 7'(MAX_ROWS_OUT) : 7'(hs);
      search_n   <= (32'(glyph_count) > GLYPH_SLOTS) ? CNT_W'(GLYPH_SLOTS)
                                                     : CNT_W'(glyph_count);
    end else if (out_load) begin
      ycur <= 16'(ycur + 16'd1);
    end
    if (state == ST_SCAN) begin
      chk_idx <= scan_idx[SLOT_W-1:0];
      if (chk_valid && !q_found && code_rdata == FALLBACK_CODE) begin
        q_idx <= chk_idx;
      end
      if (chk_hit) begin
        sel <= chk_idx;
      end else if (scan_done) begin
        sel <= q_found ? q_idx : '0;
      end
    end
  end

  // horizontal clip, fixed for the whole draw
  logic [MASK_W-1:0] clipx, clip_comb;
  logic [16:0]       xk;

  always_comb begin
    clip_comb = '0;
    xk        = '0;
    for (int k = 0; k < MASK_W; k++) begin
      xk = 17'({{2{draw_px[14]}}, draw_px} + 17'(k));
      clip_comb[k] = (7'(k) < ws) && !xk[16] && (xk[15:0] < {3'd0, screen_width});
    end
  end

  always_ff @(posedge clk) begin
    clipx <= clip_comb;
  end

  // horizontal scaling of the glyph row; column of bit k is k / scale
  logic [MASK_W-1:0] fg_comb;
  logic [5:0]        col;

  always_comb begin
    fg_comb = '0;
    col     = '0;
    for (int k = 0; k < MASK_W; k++) begin
      case (scale)
        3'd1:    col = 6'(k);
        3'd2:    col = 6'(k >> 1);
        3'd3:    col = 6'((k * 43) >> 7);
        3'd4:    col = 6'(k >> 2);
        default: col = '0;
      endcase
      fg_comb[k] = (col < {1'b0, w}) && bmp_rdata[~col[3:0]];
    end
  end

  logic        vis;
  logic [26:0] base_prod;

  assign vis       = !ycur[15] && ({1'b0, ycur[14:0]} < {3'd0, screen_height});
  assign base_prod = ycur[12:0] * line_pitch;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_y      <= ycur;
      row_base   <= vis ? base_prod[24:0] : 25'd0;
      start_x    <= {draw_px[14], draw_px};
      fg_mask    <= fg_comb;
      write_mask <= vis ? clipx : '0;
      fg_color   <= draw_color;
      last_row   <= row_last;
    end
  end

`ifndef SYNTHESIS
  a_mem_write_idle: assert property (@(posedge clk) disable iff (rst)
    code_we |-> state == ST_IDLE)
    else $error("glyph memory written outside idle");

  a_last_ends_draw: assert property (@(posedge clk) disable iff (rst)
    (out_load && row_last) |=> state == ST_IDLE)
    else $error("draw continued past its final row");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> r < rows)
    else $error("row counter passed row count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_idx <= search_n)
    else $error("slot scan ran past glyph count");

  a_glyph_row_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROW_RD |-> {1'b0, gr} < h)
    else $error("glyph row read beyond glyph height");
`endif

endmodule
